/* hw/rtl/entf_pkg.sv */
`default_nettype none
package entf_pkg;

  localparam int MAX_STEPS = 16;
  localparam int STEP_AW = $clog2(MAX_STEPS);
  localparam int STEP_CW = STEP_AW + 1;
  localparam int ENTRY_W = 39;
  localparam int CFG_W = 43;
  localparam int CFG_AW = 3;
  localparam int MUL_W = 33;
  localparam int DIV_NW = 60;
  localparam int DIV_QW = 30;
  localparam int DIV_CW = $clog2(DIV_QW);

  localparam logic [CFG_AW-1:0] REG_MAX_FORCE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CONT_FORCE = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_POWER = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MIN_ACCEL = 3'd3;
  localparam logic [CFG_AW-1:0] REG_EFFICIENCY = 3'd4;
  localparam logic [CFG_AW-1:0] REG_POWER_FACTOR = 3'd5;
  localparam logic [CFG_AW-1:0] REG_NOTCH_TOTAL = 3'd6;
  localparam logic [CFG_AW-1:0] REG_STEP_ENTRY = 3'd7;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [16:0] PF_LOW = 17'd32768;
  localparam logic [30:0] X_CAP = 31'd536870912;

endpackage
`default_nettype wire

/* hw/rtl/entf_ram.sv */
`default_nettype none
module entf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wen,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/electric_notch_tractive_force.sv */
// a neutral beat goes from idle straight to ST_OUT; any other beat passes the step search
// (if the table is not empty), one shared 33x33 multiplier and one radix-2 divider
// (30 quotient bits at one cycle a bit, up to two divisions, skipped when the quotient saturates)
// one beat at a time: s_tready is high only in idle; a result that waits on m_tready
// holds the next result and so the input
// reset (rst, synchronous): registers to defaults, step index and last force zero, table empty
`default_nettype none
module electric_notch_tractive_force
  import entf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [39:0]       s_tdata,   // throttle_q16, direction, speed_q8
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [31:0]       m_tdata,   // force_newtons, pantograph_forward,
                                            // pantograph_reverse, active_step
  input  wire logic              cfg_write,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_NI   = 5'd1;
  localparam logic [4:0] ST_R0   = 5'd2;
  localparam logic [4:0] ST_D0   = 5'd3;
  localparam logic [4:0] ST_R1   = 5'd4;
  localparam logic [4:0] ST_D1   = 5'd5;
  localparam logic [4:0] ST_UP   = 5'd6;
  localparam logic [4:0] ST_RN   = 5'd7;
  localparam logic [4:0] ST_DN   = 5'd8;
  localparam logic [4:0] ST_RV   = 5'd9;
  localparam logic [4:0] ST_DV   = 5'd10;
  localparam logic [4:0] ST_C1   = 5'd11;
  localparam logic [4:0] ST_C2   = 5'd12;
  localparam logic [4:0] ST_C3   = 5'd13;
  localparam logic [4:0] ST_C4   = 5'd14;
  localparam logic [4:0] ST_C5   = 5'd15;
  localparam logic [4:0] ST_C6   = 5'd16;
  localparam logic [4:0] ST_C7   = 5'd17;
  localparam logic [4:0] ST_C8   = 5'd18;
  localparam logic [4:0] ST_C9   = 5'd19;
  localparam logic [4:0] ST_C10  = 5'd20;
  localparam logic [4:0] ST_C11  = 5'd21;
  localparam logic [4:0] ST_FQ   = 5'd22;
  localparam logic [4:0] ST_P1   = 5'd23;
  localparam logic [4:0] ST_P2   = 5'd24;
  localparam logic [4:0] ST_P3   = 5'd25;
  localparam logic [4:0] ST_P4   = 5'd26;
  localparam logic [4:0] ST_P5   = 5'd27;
  localparam logic [4:0] ST_P6   = 5'd28;
  localparam logic [4:0] ST_DIV  = 5'd29;
  localparam logic [4:0] ST_OUT  = 5'd30;

  logic [23:0] max_force;
  logic [23:0] cont_force;
  logic [25:0] max_power;
  logic [23:0] min_accel;
  logic [15:0] eff;
  logic [16:0] pf;
  logic [5:0]  notch_total;
  logic [STEP_CW-1:0] step_count;

  logic [4:0]  state;
  logic [4:0]  ret;
  logic [16:0] thr;
  logic [1:0]  dir;
  logic [15:0] spd;
  logic [5:0]  ni;
  logic [STEP_AW-1:0] cur;
  logic [5:0]  nc;
  logic [STEP_AW-1:0] step_index;
  logic [23:0] prev_force;
  logic [16:0] v;
  logic [15:0] r;
  logic [20:0] xa;
  logic [29:0] x;
  logic [16:0] pf2;
  logic [9:0]  yhi;
  logic [65:0] tlo;
  logic [43:0] dd;
  logic [47:0] lhs;
  logic [23:0] f;
  logic [65:0] prod;

  logic [DIV_NW-1:0]          rem;
  logic [DIV_NW+DIV_QW-2:0]   dsh;
  logic [DIV_QW-1:0]          quo;
  logic [DIV_CW-1:0]          cnt;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [STEP_AW-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic              div_go;
  logic [DIV_NW-1:0] div_n;
  logic [DIV_NW-1:0] div_d;
  logic [4:0]        div_ret;

  logic [16:0] pf_sat;
  logic [25:0] pmax;
  logic [STEP_AW-1:0] top;
  logic [5:0]  rd_notch;
  logic [16:0] thr_in;
  logic [15:0] spd_in;
  logic [STEP_AW-1:0] cur_in;
  logic [22:0] ni_sum;
  logic [30:0] x_sum;
  logic [59:0] d_sum;
  logic [43:0] d_val;
  logic        neutral;
  logic        fwd;
  logic [24:0] force_out;

  assign s_tready = (state == ST_IDLE);
  assign pf_sat = (pf < PF_LOW) ? PF_LOW : ((pf > ONE_Q16) ? ONE_Q16 : pf);
  assign pmax = (max_power == 26'd0) ? 26'd1 : max_power;
  assign top = STEP_AW'(step_count - STEP_CW'(1));
  assign rd_notch = rd_data[38:33];
  assign thr_in = (s_tdata[16:0] > ONE_Q16) ? ONE_Q16 : s_tdata[16:0];
  assign spd_in = s_tdata[34] ? 16'(17'h10000 - {1'b0, s_tdata[34:19]}) : s_tdata[34:19];
  assign cur_in = (STEP_CW'(step_index) > STEP_CW'(top)) ? top : step_index;
  assign ni_sum = prod[22:0] + 23'd32768;
  assign x_sum = {10'd0, xa} + {1'b0, quo};
  assign d_sum = tlo[59:0] + {prod[26:0], 33'd0};
  assign d_val = d_sum[59:16] + 44'd65536 - {27'd0, pf2};
  assign neutral = (dir == 2'b00);
  assign fwd = (dir == 2'b01);
  assign force_out = fwd ? {1'b0, f} : 25'(-{1'b0, f});

  entf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_STEPS)
  ) u_table (
    .clk  (clk),
    .wen  (cfg_write && (cfg_index == REG_STEP_ENTRY)),
    .waddr(cfg_data[42:39]),
    .wdata(cfg_data[ENTRY_W-1:0]),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    rd_addr = cur;
    div_go = 1'b0;
    div_n = '0;
    div_d = '0;
    div_ret = ST_FQ;
    unique case (state)
      ST_NI: begin
        mul_a = MUL_W'(thr);
        mul_b = MUL_W'(notch_total);
      end
      ST_RN: begin
        rd_addr = STEP_AW'(cur + STEP_AW'(1));
      end
      ST_C1: begin
        mul_a = MUL_W'(r);
        mul_b = MUL_W'(ONE_Q16 - {1'b0, eff});
      end
      ST_C2: begin
        mul_a = MUL_W'(eff);
        mul_b = MUL_W'(spd);
      end
      ST_C3: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(cont_force);
      end
      ST_C4: begin
        div_go = 1'b1;
        div_n = prod[DIV_NW-1:0];
        div_d = DIV_NW'({pmax, 8'd0});
        div_ret = ST_C5;
      end
      ST_C5: begin
        mul_a = MUL_W'(pf_sat);
        mul_b = MUL_W'(pf_sat);
      end
      ST_C6: begin
        mul_a = MUL_W'(x);
        mul_b = MUL_W'(x);
      end
      ST_C7: begin
        mul_a = MUL_W'(pf2);
        mul_b = prod[48:16];
      end
      ST_C8: begin
        mul_a = MUL_W'(pf2);
        mul_b = MUL_W'(yhi);
      end
      ST_C9: begin
        mul_a = MUL_W'(v);
        mul_b = MUL_W'(v);
      end
      ST_C10: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(cont_force);
      end
      ST_C11: begin
        div_go = 1'b1;
        div_n = prod[DIV_NW-1:0];
        div_d = {dd, 16'd0};
        div_ret = ST_FQ;
      end
      ST_P1: begin
        mul_a = MUL_W'(max_force);
        mul_b = MUL_W'(spd);
      end
      ST_P2: begin
        mul_a = MUL_W'(v);
        mul_b = MUL_W'(max_power);
      end
      ST_P3: begin
        mul_a = MUL_W'(v);
        mul_b = (lhs > prod[47:0]) ? MUL_W'(v) : MUL_W'(max_force);
      end
      ST_P4: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(max_power);
      end
      ST_P5: begin
        div_go = 1'b1;
        div_n = prod[DIV_NW-1:0];
        div_d = DIV_NW'({spd, 24'd0});
        div_ret = ST_FQ;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 66'(mul_a) * 66'(mul_b);
    if (rst) begin
      max_force <= '0;
      cont_force <= '0;
      max_power <= 26'd1;
      min_accel <= '0;
      eff <= 16'd58982;
      pf <= ONE_Q16;
      notch_total <= 6'd8;
      step_count <= '0;
      state <= ST_IDLE;
      step_index <= '0;
      prev_force <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MAX_FORCE:    max_force <= cfg_data[23:0];
          REG_CONT_FORCE:   cont_force <= cfg_data[23:0];
          REG_MAX_POWER:    max_power <= cfg_data[25:0];
          REG_MIN_ACCEL:    min_accel <= cfg_data[23:0];
          REG_EFFICIENCY:   eff <= cfg_data[15:0];
          REG_POWER_FACTOR: pf <= cfg_data[16:0];
          REG_NOTCH_TOTAL:  notch_total <= cfg_data[5:0];
          REG_STEP_ENTRY:   step_count <= STEP_CW'({1'b0, cfg_data[42:39]} + 5'd1);
          default: begin
          end
        endcase
      end
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      if (div_go) begin
        rem <= div_n;
        dsh <= (DIV_NW+DIV_QW-1)'(div_d) << (DIV_QW - 1);
        cnt <= DIV_CW'(DIV_QW - 1);
        ret <= div_ret;
        if ({{DIV_QW{1'b0}}, div_n} >= {div_d, {DIV_QW{1'b0}}}) begin
          quo <= '1;
          state <= div_ret;
        end else begin
          quo <= '0;
          state <= ST_DIV;
        end
      end else begin
        unique case (state)
          ST_IDLE: begin
            if (s_tvalid) begin
              thr <= thr_in;
              dir <= s_tdata[18:17];
              spd <= spd_in;
              cur <= cur_in;
              if (s_tdata[18:17] == 2'b00) begin
                state <= ST_OUT;
              end else if (step_count == '0) begin
                v <= thr_in;
                r <= 16'd4096;
                state <= (cont_force != '0) ? ST_C1 : ST_P1;
              end else begin
                state <= ST_NI;
              end
            end
          end
          ST_NI: state <= ST_R0;
          ST_R0: begin
            ni <= ni_sum[21:16];
            state <= ST_D0;
          end
          ST_D0: begin
            if ((ni < rd_notch) && (cur != '0)) begin
              cur <= STEP_AW'(cur - STEP_AW'(1));
              state <= ST_R1;
            end else begin
              nc <= rd_notch;
              state <= ST_UP;
            end
          end
          ST_R1: state <= ST_D1;
          ST_D1: begin
            nc <= rd_notch;
            state <= ST_UP;
          end
          ST_UP: begin
            state <= ST_RV;
            if ((min_accel == '0) && (cur < top) && (ni > nc)) begin
              cur <= STEP_AW'(cur + STEP_AW'(1));
            end else if ((min_accel != '0) && (prev_force < min_accel) && (cur < top)) begin
              if (ni > nc) begin
                cur <= STEP_AW'(cur + STEP_AW'(1));
              end else if (ni == nc) begin
                state <= ST_RN;
              end
            end
          end
          ST_RN: state <= ST_DN;
          ST_DN: begin
            if (rd_notch == ni) begin
              cur <= STEP_AW'(cur + STEP_AW'(1));
            end
            state <= ST_RV;
          end
          ST_RV: state <= ST_DV;
          ST_DV: begin
            v <= (rd_data[32:16] > ONE_Q16) ? ONE_Q16 : rd_data[32:16];
            r <= rd_data[15:0];
            step_index <= cur;
            state <= (cont_force != '0) ? ST_C1 : ST_P1;
          end
          ST_C1: state <= ST_C2;
          ST_C2: begin
            xa <= prod[32:12];
            state <= ST_C3;
          end
          ST_C3: state <= ST_C4;
          ST_C5: begin
            x <= (x_sum > X_CAP) ? X_CAP[29:0] : x_sum[29:0];
            state <= ST_C6;
          end
          ST_C6: begin
            pf2 <= prod[32:16];
            state <= ST_C7;
          end
          ST_C7: begin
            yhi <= prod[58:49];
            state <= ST_C8;
          end
          ST_C8: begin
            tlo <= prod;
            state <= ST_C9;
          end
          ST_C9: begin
            dd <= d_val;
            state <= ST_C10;
          end
          ST_C10: begin
            if (dd == '0) begin
              f <= max_force;
              state <= ST_OUT;
            end else begin
              state <= ST_C11;
            end
          end
          ST_FQ: begin
            f <= (quo > DIV_QW'(max_force)) ? max_force : quo[23:0];
            state <= ST_OUT;
          end
          ST_P1: state <= ST_P2;
          ST_P2: begin
            lhs <= {prod[39:0], 8'd0};
            state <= ST_P3;
          end
          ST_P3: begin
            state <= (lhs > prod[47:0]) ? ST_P4 : ST_P6;
          end
          ST_P4: state <= ST_P5;
          ST_P6: begin
            f <= prod[39:16];
            state <= ST_OUT;
          end
          ST_DIV: begin
            if ((DIV_NW+DIV_QW-1)'(rem) >= dsh) begin
              rem <= DIV_NW'((DIV_NW+DIV_QW-1)'(rem) - dsh);
              quo[cnt] <= 1'b1;
            end
            dsh <= dsh >> 1;
            cnt <= DIV_CW'(cnt - DIV_CW'(1));
            if (cnt == '0) begin
              state <= ret;
            end
          end
          ST_OUT: begin
            if (!m_tvalid || m_tready) begin
              m_tvalid <= 1'b1;
              if (neutral) begin
                m_tdata <= {1'b0, step_index, 2'b00, 25'd0};
              end else begin
                m_tdata <= {1'b0, step_index, dir[1], fwd, force_out};
                prev_force <= f;
              end
              state <= ST_IDLE;
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a beat is in work");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[25] && m_tdata[26]))
    else $error("both pantograph flags raised");

  a_neutral_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[25] && !m_tdata[26] |-> m_tdata[24:0] == 25'd0)
    else $error("neutral beat with nonzero force");

endmodule
`default_nettype wire

/* sim/electric_notch_tractive_force_tb.sv */
`timescale 1ns / 1ps
module electric_notch_tractive_force_tb;
  import entf_pkg::*;

  typedef struct packed {
    logic [15:0] speed_q8;
    logic [1:0]  direction;
    logic [16:0] throttle_q16;
  } tick_t;

  typedef struct packed {
    logic [3:0]  active_step;
    logic        pant_rev;
    logic        pant_fwd;
    logic [24:0] force_newtons;
  } force_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;
  logic cfg_write = 0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_tready_q = 0;

  electric_notch_tractive_force i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  longint unsigned f_max, f_cont, p_max, f_min, eff, pf, notches;
  longint unsigned t_notch[MAX_STEPS];
  longint unsigned t_volt[MAX_STEPS];
  longint unsigned t_res[MAX_STEPS];
  longint unsigned cur_step, last_force, n_steps;

  tick_t  pending_ticks[$];
  force_t expected_forces[$];
  int     errors = 0;
  int     sent = 0;
  bit     quiet = 0;
  bit     hold_rx = 0;
  bit     pause_tx = 0;
  int     hold_count = 0;

  initial forever #2 clk = ~clk;

  initial begin
    #400000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint unsigned sat_one(longint unsigned v);
    return v > 65536 ? 65536 : v;
  endfunction

  function automatic longint unsigned curve_force(longint unsigned v, longint unsigned r,
                                                  longint unsigned s);
    longint unsigned p, q, x, q2, d, f;
    p = p_max != 0 ? p_max : 1;
    q = pf < 32768 ? 32768 : (pf > 65536 ? 65536 : pf);
    x = (r * (65536 - eff)) >> 12;
    x += (eff * s * f_cont) / (p << 8);
    if (x > 64'd536870912) x = 64'd536870912;
    q2 = (q * q) >> 16;
    d = ((q2 * ((x * x) >> 16)) >> 16) + (65536 - q2);
    if (d == 0) return f_max;
    f = (v * v * f_cont) / (d << 16);
    return f > f_max ? f_max : f;
  endfunction

  function automatic longint unsigned power_force(longint unsigned v, longint unsigned s);
    if (f_max * s * 256 > v * p_max) return (v * v * p_max) / (s << 24);
    return (v * f_max) >> 16;
  endfunction

  function automatic force_t predict_force(tick_t t);
    force_t o;
    longint unsigned thr, s, v, r, f, top, cur, i;
    thr = sat_one(t.throttle_q16);
    s = t.speed_q8[15] ? 64'h10000 - t.speed_q8 : t.speed_q8;
    v = thr;
    r = 4096;
    o = '0;
    if (t.direction == 2'b00) begin
      o.active_step = cur_step[3:0];
      return o;
    end
    if (n_steps > 0) begin
      top = n_steps - 1;
      cur = cur_step > top ? top : cur_step;
      i = (thr * notches + 32768) >> 16;
      if (i < t_notch[cur] && cur > 0) cur--;
      if (f_min == 0 && cur < top && i > t_notch[cur]) cur++;
      if (f_min > 0 && last_force < f_min && cur < top &&
          (i > t_notch[cur] || (i == t_notch[cur] && i == t_notch[cur + 1])))
        cur++;
      cur_step = cur;
      v = sat_one(t_volt[cur]);
      r = t_res[cur];
    end
    f = f_cont > 0 ? curve_force(v, r, s) : power_force(v, s);
    last_force = f & 64'hFFFFFF;
    o.force_newtons = t.direction == 2'b01 ? f[24:0] : 25'(-f);
    o.pant_fwd = t.direction == 2'b01;
    o.pant_rev = t.direction != 2'b01;
    o.active_step = cur_step[3:0];
    return o;
  endfunction

  task automatic write_reg(logic [CFG_AW-1:0] idx, longint unsigned val);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_write <= 0;
    case (idx)
      REG_MAX_FORCE: f_max = val & 64'hFFFFFF;
      REG_CONT_FORCE: f_cont = val & 64'hFFFFFF;
      REG_MAX_POWER: p_max = val & 64'h3FFFFFF;
      REG_MIN_ACCEL: f_min = val & 64'hFFFFFF;
      REG_EFFICIENCY: eff = val & 64'hFFFF;
      REG_POWER_FACTOR: pf = val & 64'h1FFFF;
      REG_NOTCH_TOTAL: notches = val & 64'h3F;
      REG_STEP_ENTRY: begin
        t_notch[(val >> 39) & 15] = (val >> 33) & 64'h3F;
        t_volt[(val >> 39) & 15] = (val >> 16) & 64'h1FFFF;
        t_res[(val >> 39) & 15] = val & 64'hFFFF;
        n_steps = ((val >> 39) & 15) + 1;
      end
      default: ;
    endcase
  endtask

  task automatic write_table(int n, bit maxed);
    longint unsigned e;
    for (int k = 0; k < n; k++) begin
      if (maxed && k == n - 1)
        e = {4'(k), 6'h3F, 17'h1FFFF, 16'hFFFF};
      else
        e = {4'(k), 6'(k * 50 / n + (k > 0)), 17'($urandom_range(0, 70000)),
             16'($urandom)};
      write_reg(REG_STEP_ENTRY, e);
    end
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    int r;
    r = $urandom_range(0, 9);
    t.throttle_q16 = r == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536));
    t.direction = r < 2 ? 2'($urandom) : (r < 6 ? 2'b01 : 2'b11);
    t.speed_q8 = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8000));
    return t;
  endfunction

  task automatic drain();
    wait (pending_ticks.size() == 0 && expected_forces.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic push(logic [16:0] thr, logic [1:0] dir, logic [15:0] spd);
    tick_t t;
    t.throttle_q16 = thr;
    t.direction = dir;
    t.speed_q8 = spd;
    pending_ticks.insert(pending_ticks.size(), t);
  endtask

  task automatic add_random(int n);
    for (int k = 0; k < n; k++) pending_ticks.insert(pending_ticks.size(), rand_tick());
  endtask

  task automatic run_random(int n);
    add_random(n);
    drain();
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready_q) begin
        if (pending_ticks.size() > 0 && !pause_tx && (quiet || $urandom_range(0, 99) >= 26)) begin
          s_tdata <= {5'b0, pending_ticks[0]};
          s_tvalid <= 1;
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // acceptance seen at the rising edge
  always @(posedge clk) begin
    s_tready_q <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_forces.insert(expected_forces.size(), predict_force(tick_t'(s_tdata[34:0])));
      void'(pending_ticks.pop_front());
      sent++;
    end
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 0;
    else if (hold_rx) m_tready <= 0;
    else m_tready <= quiet || $urandom_range(0, 99) >= 26;
  end

  // monitor
  always @(posedge clk) begin
    force_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = force_t'(m_tdata[30:0]);
      if (expected_forces.size() == 0) begin
        $error("result with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        want = expected_forces.pop_front();
        if (got.force_newtons !== want.force_newtons) begin
          $error("force_newtons exp %h got %h", want.force_newtons, got.force_newtons);
          errors++;
        end
        if (got.pant_fwd !== want.pant_fwd) begin
          $error("pantograph_forward exp %b got %b", want.pant_fwd, got.pant_fwd);
          errors++;
        end
        if (got.pant_rev !== want.pant_rev) begin
          $error("pantograph_reverse exp %b got %b", want.pant_rev, got.pant_rev);
          errors++;
        end
        if (got.active_step !== want.active_step) begin
          $error("active_step exp %0d got %0d", want.active_step, got.active_step);
          errors++;
        end
      end
    end
  end

  initial begin
    int w;
    f_max = 0; f_cont = 0; p_max = 1; f_min = 0; eff = 58982; pf = 65536; notches = 8;
    cur_step = 0; last_force = 0; n_steps = 0;
    for (int k = 0; k < MAX_STEPS; k++) begin
      t_notch[k] = 0; t_volt[k] = 0; t_res[k] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // empty table, constant power curve
    write_reg(REG_MAX_FORCE, 200000);
    write_reg(REG_MAX_POWER, 3000000);
    push(17'd65536, 2'b01, 16'd0);
    push(17'h1FFFF, 2'b01, 16'd2560);
    push(17'd0, 2'b11, 16'h8000);
    push(17'd40000, 2'b10, 16'h7FFF);
    push(17'd30000, 2'b00, 16'd100);
    drain();

    // table, curve, plain notching
    write_reg(REG_MAX_FORCE, 24'hFFFFFF);
    write_reg(REG_CONT_FORCE, 150000);
    write_reg(REG_MAX_POWER, 0);
    write_reg(REG_EFFICIENCY, 32768);
    write_reg(REG_POWER_FACTOR, 17'h1FFFF);
    write_reg(REG_NOTCH_TOTAL, 50);
    write_table(MAX_STEPS, 1);
    write_reg(REG_STEP_ENTRY, {4'd15, 39'd0} | 43'h0); // rewrite last entry as zero
    for (int k = 0; k < 12; k++) push(17'd65536, 2'b01, 16'($urandom));
    for (int k = 0; k < 6; k++) push(17'd0, 2'b11, 16'hFFFF);
    push(17'd65536, 2'b00, 16'd0);
    drain();

    // minimum force notching, extremes of registers
    write_reg(REG_MIN_ACCEL, 24'hFFFFFF);
    write_reg(REG_POWER_FACTOR, 0);
    write_reg(REG_EFFICIENCY, 65535);
    write_reg(REG_NOTCH_TOTAL, 1);
    write_reg(REG_MAX_POWER, 26'h3FFFFFF);
    run_random(250);

    write_reg(REG_NOTCH_TOTAL, 63);
    write_reg(REG_POWER_FACTOR, 49152);
    write_reg(REG_MIN_ACCEL, 50000);
    write_reg(REG_MAX_POWER, 1);
    write_table(4, 0);
    run_random(250);

    // fill up the block while the receiver holds off
    hold_rx = 1;
    add_random(20);
    hold_count = 0;
    while (hold_count < 3000) begin
      @(posedge clk);
      hold_count++;
    end
    hold_rx = 0;
    drain();

    write_reg(REG_MIN_ACCEL, 0);
    write_reg(REG_CONT_FORCE, 0);
    write_reg(REG_MAX_POWER, $urandom_range(100000, 5000000));
    write_reg(REG_MAX_FORCE, $urandom_range(0, 400000));
    write_table(8, 0);
    quiet = 1;
    run_random(260);
    quiet = 0;

    // sender pauses until all results are in
    add_random(40);
    repeat (400) @(posedge clk);
    pause_tx = 1;
    wait (expected_forces.size() == 0 && !s_tvalid);
    repeat (50) @(posedge clk);
    pause_tx = 0;
    drain();

    for (w = 0; w < 3; w++) begin
      write_reg(REG_CONT_FORCE, w == 0 ? 24'hFFFFFF : $urandom_range(1, 400000));
      write_reg(REG_MAX_FORCE, $urandom_range(1, 24'hFFFFFF));
      write_reg(REG_MAX_POWER, $urandom_range(1, 26'h3FFFFFF));
      write_reg(REG_EFFICIENCY, $urandom_range(32768, 65535));
      write_reg(REG_POWER_FACTOR, $urandom_range(32768, 65536));
      write_reg(REG_MIN_ACCEL, w == 1 ? $urandom_range(1, 300000) : 0);
      write_reg(REG_NOTCH_TOTAL, $urandom_range(1, 50));
      write_table($urandom_range(2, MAX_STEPS), 0);
      run_random(250);
    end

    if (errors == 0 && expected_forces.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/entf_pkg.sv
hw/rtl/entf_ram.sv
hw/rtl/electric_notch_tractive_force.sv
sim/electric_notch_tractive_force_tb.sv
